// ===== rtl/core/sdf_pkg.sv =====
// Package for the signed decimal field formatter.
// Holds the BCD digit type, the ASCII constants and the digit adjust function.
// No dependencies.
`default_nettype none

package sdf_pkg;

  localparam int NDIG = 10;
  localparam int MAG_W = 32;

  typedef logic [NDIG-1:0][3:0] bcd_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  function automatic logic [3:0] dd_adjust(input logic [3:0] d);
    dd_adjust = (d >= 4'd5) ? 4'(d + 4'd3) : d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdf_b2d.sv =====
// Iterative binary to BCD converter, one bit per cycle (shift and add three).
// Depends on sdf_pkg.
`default_nettype none

module sdf_b2d (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [31:0]  mag,
  output sdf_pkg::bcd_t     digits,
  output logic              done
);
  import sdf_pkg::*;

  logic [MAG_W-1:0] sh;
  logic [4:0]       cnt;
  logic             run;
  bcd_t             adj;
  logic [4*NDIG-1:0] adj_flat;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = dd_adjust(digits[i]);
    end
    adj_flat = adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run    <= 1'b1;
        cnt    <= 5'd31;
        sh     <= mag;
        digits <= '0;
      end else if (run) begin
        digits <= {adj_flat[4*NDIG-2:0], sh[MAG_W-1]};
        sh     <= {sh[MAG_W-2:0], 1'b0};
        cnt    <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !run) else $error("converter still running after done");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> run && cnt == 5'd31) else $error("converter did not start");
  a_done_after_zero: assert property (@(posedge clk) disable iff (rst)
    run && cnt == 5'd0 && !start |=> done) else $error("converter missed done");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sdf_emit.sv =====
// Character sequencer: walks a position counter over the planned field and
// emits one character per cycle. Depends on sdf_pkg.
`default_nettype none

module sdf_emit #(
  parameter int CW = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [4:0][CW-1:0]   bounds,
  input  wire logic [7:0]           sign_ch,
  input  sdf_pkg::bcd_t             digits,
  output logic                      strobe,
  output logic [7:0]                char_out,
  output logic                      last,
  output logic                      done
);
  import sdf_pkg::*;

  logic [CW-1:0] pos;
  logic          active;
  logic [CW-1:0] didx;
  logic [7:0]    ch;
  logic          fin;

  assign didx = CW'(bounds[3] - pos - 1'b1);
  assign fin  = (pos == CW'(bounds[4] - 1'b1));

  always_comb begin
    priority if (pos < bounds[0]) begin
      ch = CH_SPACE;
    end else if (pos < bounds[1]) begin
      ch = sign_ch;
    end else if (pos < bounds[2]) begin
      ch = CH_ZERO;
    end else if (pos < bounds[3]) begin
      ch = CH_ZERO + {4'b0, digits[didx[3:0]]};
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      last   <= 1'b0;
      done   <= 1'b0;
      pos    <= '0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      done   <= 1'b0;
      if (go) begin
        pos    <= '0;
        active <= (bounds[4] != '0);
        done   <= (bounds[4] == '0);
      end else if (active) begin
        strobe   <= 1'b1;
        char_out <= ch;
        last     <= fin;
        pos      <= pos + 1'b1;
        if (fin) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_field: assert property (@(posedge clk) disable iff (rst)
    active |-> pos < bounds[4]) else $error("position ran past the field");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe && done) else $error("last word without done");
  a_no_go_while_active: assert property (@(posedge clk) disable iff (rst)
    active |-> !go) else $error("new plan while emitting");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/signed_decimal_field_formatter.sv =====
// Flow: after start is accepted, the value passes the 32-step bit-serial BCD
// conversion, a planning state and the one-word-per-cycle sequencer, which
// gives N words for an N-character field. A new item is accepted only when
// idle, after the last word of the previous item has been emitted.
// Reset: synchronous active-high rst returns to idle with no word pending.
// The receiver cannot stall; strobe marks each word for exactly one cycle.
`default_nettype none

module signed_decimal_field_formatter #(
  parameter int MAX_FIELD = 63
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [31:0]  value,
  input  wire logic         left_justify,
  input  wire logic         zero_pad,
  input  wire logic         force_plus,
  input  wire logic         space_sign,
  input  wire logic [5:0]   field_width,
  input  wire logic         has_precision,
  input  wire logic [5:0]   min_digits,
  output logic              strobe,
  output logic [7:0]        char_out,
  output logic              last
);
  import sdf_pkg::*;

  localparam int CW = $clog2(MAX_FIELD + 2);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PLAN, ST_EMIT} state_t;

  state_t state;

  logic          left;
  logic          zpad;
  logic          has_p;
  logic          has_sign;
  logic [7:0]    sign_ch;
  logic [CW-1:0] w;
  logic [CW-1:0] p;
  logic [4:0][CW-1:0] bounds;
  logic          go;

  logic [31:0]   mag;
  logic          b2d_start;
  bcd_t          digits;
  logic          conv_done;
  logic          emit_done;

  logic [3:0]    nd_raw;
  logic [CW-1:0] nd;
  logic [CW-1:0] lead;
  logic [CW-1:0] body;
  logic [CW-1:0] pad;
  logic [CW-1:0] extra;
  logic [4:0][CW-1:0] bounds_next;

  assign busy      = (state != ST_IDLE);
  assign b2d_start = start && !busy;
  assign mag       = value[31] ? 32'(~value + 32'd1) : value;

  sdf_b2d u_b2d (
    .clk    (clk),
    .rst    (rst),
    .start  (b2d_start),
    .mag    (mag),
    .digits (digits),
    .done   (conv_done)
  );

  always_comb begin
    nd_raw = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      if (digits[i] != 4'd0) begin
        nd_raw = 4'(i + 1);
      end
    end
    if (nd_raw == 4'd0 && !(has_p && p == '0)) begin
      nd_raw = 4'd1;
    end
    nd    = CW'(nd_raw);
    lead  = (has_p && p > nd) ? CW'(p - nd) : '0;
    body  = CW'({{(CW-1){1'b0}}, has_sign} + lead + nd);
    extra = (w > body) ? CW'(w - body) : '0;
    pad   = '0;
    if (zpad && !left && !has_p) begin
      lead = CW'(lead + extra);
    end else begin
      pad = extra;
    end
    bounds_next[0] = left ? '0 : pad;
    bounds_next[1] = CW'(bounds_next[0] + {{(CW-1){1'b0}}, has_sign});
    bounds_next[2] = CW'(bounds_next[1] + lead);
    bounds_next[3] = CW'(bounds_next[2] + nd);
    bounds_next[4] = left ? CW'(bounds_next[3] + pad) : bounds_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go    <= 1'b0;
    end else begin
      go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_CONV;
            left     <= left_justify;
            zpad     <= zero_pad;
            has_p    <= has_precision;
            has_sign <= value[31] || force_plus || space_sign;
            sign_ch  <= value[31] ? CH_MINUS : (force_plus ? CH_PLUS : CH_SPACE);
            w        <= (32'(field_width) > 32'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                            : CW'(field_width);
            p        <= (32'(min_digits) > 32'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                           : CW'(min_digits);
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            state <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          bounds <= bounds_next;
          go     <= 1'b1;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sdf_emit #(.CW(CW)) u_emit (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .bounds   (bounds),
    .sign_ch  (sign_ch),
    .digits   (digits),
    .strobe   (strobe),
    .char_out (char_out),
    .last     (last),
    .done     (emit_done)
  );

`ifndef ASSERT_OFF
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> state == ST_EMIT) else $error("word outside emit phase");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not set busy");
  a_field_bound: assert property (@(posedge clk) disable iff (rst)
    go |-> 32'(bounds[4]) <= 32'(MAX_FIELD) + 1) else $error("field too long");
  a_done_in_emit: assert property (@(posedge clk) disable iff (rst)
    emit_done |-> state == ST_EMIT) else $error("sequencer done while not emitting");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_signed_decimal_field_formatter.sv =====
`timescale 1ns / 1ps
// Testbench for signed_decimal_field_formatter, the printf %d field formatter.
// It predicts every character word of each accepted integer and checks the
// strobed words in order. It depends on sdf_pkg and on the formatter RTL.

module tb_signed_decimal_field_formatter;
  import sdf_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [31:0] value;
    logic        left_justify;
    logic        zero_pad;
    logic        force_plus;
    logic        space_sign;
    logic [5:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
  } fmt_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] value;
  logic        left_justify;
  logic        zero_pad;
  logic        force_plus;
  logic        space_sign;
  logic [5:0]  field_width;
  logic        has_precision;
  logic [5:0]  min_digits;
  logic        strobe;
  logic [7:0]  char_out;
  logic        last;

  char_word_t expected_chars[$];
  int         error_count = 0;
  int         stall_cycles = 0;

  signed_decimal_field_formatter u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .left_justify (left_justify),
    .zero_pad     (zero_pad),
    .force_plus   (force_plus),
    .space_sign   (space_sign),
    .field_width  (field_width),
    .has_precision(has_precision),
    .min_digits   (min_digits),
    .strobe       (strobe),
    .char_out     (char_out),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_field(input fmt_item_t it);
    logic [31:0] mag;
    logic [7:0]  sign_ch;
    logic [7:0]  field[$];
    int          digits[10];
    int          ndig;
    int          lead;
    int          body;
    int          pad;
    int          i;
    bit          has_sign;
    char_word_t  w;
    ndig = 0;
    lead = 0;
    pad = 0;
    has_sign = 1'b1;
    sign_ch = CH_SPACE;
    mag = it.value[31] ? -it.value : it.value;
    if (it.value[31]) begin
      sign_ch = CH_MINUS;
    end else if (it.force_plus) begin
      sign_ch = CH_PLUS;
    end else if (!it.space_sign) begin
      has_sign = 1'b0;
    end
    while (mag != 0) begin
      digits[ndig] = int'(mag % 10);
      mag = mag / 10;
      ndig++;
    end
    if (ndig == 0 && !(it.has_precision && it.min_digits == 0)) begin
      digits[0] = 0;
      ndig = 1;
    end
    if (it.has_precision && int'(it.min_digits) > ndig) lead = int'(it.min_digits) - ndig;
    body = (has_sign ? 1 : 0) + lead + ndig;
    if (int'(it.field_width) > body) begin
      if (it.zero_pad && !it.left_justify && !it.has_precision) begin
        lead += int'(it.field_width) - body;
      end else begin
        pad = int'(it.field_width) - body;
      end
    end
    if (!it.left_justify) repeat (pad) field.push_back(CH_SPACE);
    if (has_sign) field.push_back(sign_ch);
    repeat (lead) field.push_back(CH_ZERO);
    for (i = ndig - 1; i >= 0; i--) field.push_back(CH_ZERO + 8'(digits[i]));
    if (it.left_justify) repeat (pad) field.push_back(CH_SPACE);
    foreach (field[k]) begin
      w.ch = field[k];
      w.last = (k == field.size() - 1);
      expected_chars.push_back(w);
    end
  endfunction

  function automatic fmt_item_t mk_item(input logic [31:0] v, input logic lj, input logic zp,
                                        input logic fp, input logic ss, input logic [5:0] fw,
                                        input logic hp, input logic [5:0] md);
    fmt_item_t it;
    it.value = v;
    it.left_justify = lj;
    it.zero_pad = zp;
    it.force_plus = fp;
    it.space_sign = ss;
    it.field_width = fw;
    it.has_precision = hp;
    it.min_digits = md;
    return it;
  endfunction

  function automatic fmt_item_t rand_item();
    fmt_item_t   it;
    logic [31:0] p;
    case ($urandom_range(0, 5))
      0: it.value = $urandom();
      1: it.value = 32'($urandom_range(0, 199)) - 32'd100;
      2: begin
        case ($urandom_range(0, 4))
          0: it.value = 32'h8000_0000;
          1: it.value = 32'h7FFF_FFFF;
          2: it.value = 32'd0;
          3: it.value = 32'd1;
          default: it.value = 32'hFFFF_FFFF;
        endcase
      end
      3: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        if ($urandom_range(0, 1) == 1) p = p - 1;
        if ($urandom_range(0, 1) == 1) p = -p;
        it.value = p;
      end
      default: begin
        it.value = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) it.value = -it.value;
      end
    endcase
    it.left_justify = 1'($urandom_range(0, 1));
    it.zero_pad = 1'($urandom_range(0, 1));
    it.force_plus = 1'($urandom_range(0, 1));
    it.space_sign = 1'($urandom_range(0, 1));
    it.has_precision = 1'($urandom_range(0, 1));
    it.field_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 16));
    it.min_digits = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 14));
    return it;
  endfunction

  // Called and returning at a falling edge; start is left high for a following word.
  task automatic send_item(input fmt_item_t it, input bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    value = it.value;
    left_justify = it.left_justify;
    zero_pad = it.zero_pad;
    force_plus = it.force_plus;
    space_sign = it.space_sign;
    field_width = it.field_width;
    has_precision = it.has_precision;
    min_digits = it.min_digits;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_field(it);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(mk_item(32'd0, 0, 0, 0, 0, 6'd0, 0, 6'd0), 0);
    send_item(mk_item(32'd0, 0, 0, 0, 0, 6'd0, 1, 6'd0), 0);
    send_item(mk_item(32'd0, 0, 0, 1, 0, 6'd0, 1, 6'd0), 0);
    send_item(mk_item(32'd0, 0, 0, 0, 1, 6'd0, 1, 6'd0), 0);
    send_item(mk_item(32'd0, 0, 1, 0, 0, 6'd5, 1, 6'd0), 0);
    send_item(mk_item(32'd0, 1, 0, 0, 0, 6'd4, 1, 6'd0), 0);
    send_item(mk_item(32'h8000_0000, 0, 0, 0, 0, 6'd0, 0, 6'd0), 0);
    send_item(mk_item(32'h7FFF_FFFF, 0, 0, 1, 1, 6'd0, 0, 6'd0), 0);
    send_item(mk_item(32'd123, 0, 0, 0, 1, 6'd0, 0, 6'd0), 0);
    send_item(mk_item(-32'd42, 0, 1, 0, 0, 6'd10, 0, 6'd0), 0);
    send_item(mk_item(-32'd42, 1, 1, 0, 0, 6'd10, 0, 6'd0), 0);
    send_item(mk_item(32'd42, 0, 1, 1, 0, 6'd10, 1, 6'd5), 0);
    send_item(mk_item(32'd7, 0, 0, 1, 0, 6'd0, 1, 6'd63), 0);
    send_item(mk_item(32'h8000_0000, 0, 0, 0, 0, 6'd63, 1, 6'd63), 0);
    send_item(mk_item(32'hFFFF_FFFF, 1, 0, 0, 0, 6'd63, 0, 6'd0), 0);
    send_item(mk_item(32'd1_000_000_000, 0, 1, 1, 0, 6'd63, 0, 6'd0), 0);
    send_item(mk_item(32'd5, 0, 0, 0, 0, 6'd0, 1, 6'd0), 0);
    send_item(mk_item(32'h7FFF_FFFF, 0, 0, 0, 0, 6'd63, 0, 6'd0), 0);
    send_item(mk_item(32'd0, 0, 1, 0, 1, 6'd63, 0, 6'd0), 0);
    send_item(mk_item(32'd0, 1, 1, 1, 1, 6'd63, 1, 6'd63), 0);
    wait_drain();
  endtask

  task automatic test_random_idle(input int count);
    repeat (count) send_item(rand_item(), 1);
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(2, 5)) send_item(rand_item(), 1);
      wait_drain();
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) send_item(rand_item(), 0);
  endtask

  always @(posedge clk) begin : check_words
    char_word_t exp_w;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual char %h last %b",
                 $time, char_out, last);
        error_count++;
      end else begin
        exp_w = expected_chars.pop_front();
        if (char_out !== exp_w.ch) begin
          $display("%0t: char_out mismatch, expected %h, actual %h", $time, exp_w.ch, char_out);
          error_count++;
        end
        if (last !== exp_w.last) begin
          $display("%0t: last mismatch, expected %b, actual %b", $time, exp_w.last, last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no activity for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    left_justify = 1'b0;
    zero_pad = 1'b0;
    force_plus = 1'b0;
    space_sign = 1'b0;
    field_width = '0;
    has_precision = 1'b0;
    min_digits = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_idle(180);
    test_drain_pause();
    test_back_to_back(60);
    wait_drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
